/* hw/rtl/rtwc_pkg.sv */
// ----------------------------------------------------------------------------
// rtwc_pkg
// shared types and constants for the rain tip window counter
// ----------------------------------------------------------------------------
package rtwc_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = RING_AW + 1;

  localparam logic [15:0] DEFAULT_TIP_SIZE = 16'd2794;
  localparam logic [15:0] PENDING_MAX      = 16'hFFFF;

  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_TIP_SIZE  = 3'd1;
  localparam logic [2:0] REG_MIN_LOW   = 3'd2;
  localparam logic [2:0] REG_MAX_LOW   = 3'd3;
  localparam logic [2:0] REG_MIN_GAP   = 3'd4;
  localparam logic [2:0] REG_EPOCH_THR = 3'd5;
  localparam logic [2:0] REG_HOUR_WIN  = 3'd6;
  localparam logic [2:0] REG_DAY_WIN   = 3'd7;

  localparam logic ACT_PIN  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STORE,
    ST_DAY_RD,
    ST_DAY_WAIT,
    ST_DAY_CHK,
    ST_HOUR_RD,
    ST_HOUR_WAIT,
    ST_HOUR_CHK,
    ST_MUL_HOUR,
    ST_MUL_DAY,
    ST_DONE
  } rtwc_state_t;

endpackage

/* hw/rtl/rtwc_ram.sv */
// ----------------------------------------------------------------------------
// rtwc_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module rtwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/rain_tip_window_counter.sv */
// ----------------------------------------------------------------------------
// rain_tip_window_counter
// rain gauge tip qualifier with a sliding window of tip timestamps
// ----------------------------------------------------------------------------
// usage:
//   config: write cfg_we with cfg_addr / cfg_data while the block is idle.
//   input: an item is taken when start is high and busy is low. action 0
//   is a pin change (pin_low, time_ms), action 1 is a tick (now_sec).
//   result: one item per input, shown for one cycle while done is high.
//   the receiver cannot stall; busy stays high until done has been shown.
// sequence:
//   a pin item or a tick with the clock not set goes idle, mul_hour,
//   mul_day, done. a valid tick first stores each pending tip into the
//   ring, then walks entries for the day window (day_rd, day_wait,
//   day_chk) and the hour window (hour_rd, hour_wait, hour_chk); a walk
//   that runs out of entries and the trim of the hour count to the fill
//   each take a step of their own. mul_hour and mul_day form the two rain
//   products through one shared multiplier and done shows the result.
//   the timestamp ram allows one entry to be read or written per step.
// reset: rst clears all counters and the ring pointers; registers take
//   their default values. ring contents are not cleared, unwritten entries
//   are never read.
// ----------------------------------------------------------------------------
module rain_tip_window_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic        pin_low,
  input  logic [31:0] time_ms,
  input  logic [31:0] now_sec,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic        time_valid,
  output logic [31:0] total_tips,
  output logic [10:0] hour_tips,
  output logic [10:0] day_tips,
  output logic [25:0] hour_rain,
  output logic [25:0] day_rain,
  output logic [15:0] pending_tips
);

  localparam int AW = rtwc_pkg::RING_AW;
  localparam int FW = rtwc_pkg::FILL_W;

  // configuration
  logic        enable;
  logic [15:0] tip_size, min_low_ms, max_low_ms, min_gap_ms;
  logic [31:0] epoch_threshold, hour_window_sec, day_window_sec;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= 1'b0;
      tip_size        <= rtwc_pkg::DEFAULT_TIP_SIZE;
      min_low_ms      <= 16'd15;
      max_low_ms      <= 16'd1000;
      min_gap_ms      <= 16'd250;
      epoch_threshold <= 32'd1700000000;
      hour_window_sec <= 32'd3600;
      day_window_sec  <= 32'd86400;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rtwc_pkg::REG_ENABLE:    enable          <= cfg_data[0];
        rtwc_pkg::REG_TIP_SIZE:  tip_size        <= cfg_data[15:0];
        rtwc_pkg::REG_MIN_LOW:   min_low_ms      <= cfg_data[15:0];
        rtwc_pkg::REG_MAX_LOW:   max_low_ms      <= cfg_data[15:0];
        rtwc_pkg::REG_MIN_GAP:   min_gap_ms      <= cfg_data[15:0];
        rtwc_pkg::REG_EPOCH_THR: epoch_threshold <= cfg_data;
        rtwc_pkg::REG_HOUR_WIN:  hour_window_sec <= cfg_data;
        rtwc_pkg::REG_DAY_WIN:   day_window_sec  <= cfg_data;
        default: ;
      endcase
    end
  end

  // state
  rtwc_pkg::rtwc_state_t state, state_next;
  logic          pulse_active, pulse_active_next;
  logic [31:0]   pulse_start_ms, pulse_start_ms_next;
  logic [31:0]   last_accept_ms, last_accept_ms_next;
  logic [15:0]   pending_count, pending_count_next;
  logic [31:0]   tip_total, tip_total_next;
  logic [FW-1:0] hour_count, hour_count_next;
  logic [AW-1:0] ring_head, ring_head_next;
  logic [FW-1:0] ring_fill, ring_fill_next;
  logic [15:0]   store_left, store_left_next;
  logic [31:0]   now_r, now_r_next;
  logic          valid_r, valid_r_next;
  logic [25:0]   hour_rain_r, hour_rain_next;
  logic [25:0]   day_rain_r, day_rain_next;

  // ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata;

  rtwc_ram #(.WIDTH(32), .DEPTH(rtwc_pkg::RING_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (now_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared multiplier
  logic [FW-1:0] mul_a;
  logic [15:0]   size_eff;
  logic [FW+15:0] mul_p;
  assign size_eff = (tip_size == 16'd0) ? rtwc_pkg::DEFAULT_TIP_SIZE : tip_size;
  assign mul_p    = mul_a * size_eff;

  // pin qualification
  logic [31:0] dur, gap;
  assign dur = time_ms - pulse_start_ms;
  assign gap = time_ms - last_accept_ms;

  logic [31:0] age;
  assign age = now_r - ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= rtwc_pkg::ST_IDLE;
      pulse_active   <= 1'b0;
      pulse_start_ms <= '0;
      last_accept_ms <= '0;
      pending_count  <= '0;
      tip_total      <= '0;
      hour_count     <= '0;
      ring_head      <= '0;
      ring_fill      <= '0;
      store_left     <= '0;
      valid_r        <= 1'b0;
    end else begin
      state          <= state_next;
      pulse_active   <= pulse_active_next;
      pulse_start_ms <= pulse_start_ms_next;
      last_accept_ms <= last_accept_ms_next;
      pending_count  <= pending_count_next;
      tip_total      <= tip_total_next;
      hour_count     <= hour_count_next;
      ring_head      <= ring_head_next;
      ring_fill      <= ring_fill_next;
      store_left     <= store_left_next;
      valid_r        <= valid_r_next;
    end
  end

  always_ff @(posedge clk) begin
    now_r       <= now_r_next;
    hour_rain_r <= hour_rain_next;
    day_rain_r  <= day_rain_next;
  end

  always_comb begin
    state_next          = state;
    pulse_active_next   = pulse_active;
    pulse_start_ms_next = pulse_start_ms;
    last_accept_ms_next = last_accept_ms;
    pending_count_next  = pending_count;
    tip_total_next      = tip_total;
    hour_count_next     = hour_count;
    ring_head_next      = ring_head;
    ring_fill_next      = ring_fill;
    store_left_next     = store_left;
    now_r_next          = now_r;
    valid_r_next        = valid_r;
    hour_rain_next      = hour_rain_r;
    day_rain_next       = day_rain_r;
    ram_we              = 1'b0;
    ram_waddr           = ring_head + ring_fill[AW-1:0];
    ram_raddr           = ring_head;
    mul_a               = hour_count;

    unique case (state)
      rtwc_pkg::ST_IDLE: begin
        if (start) begin
          valid_r_next = 1'b0;
          now_r_next   = now_sec;
          state_next   = rtwc_pkg::ST_MUL_HOUR;
          if (action == rtwc_pkg::ACT_PIN) begin
            if (enable) begin
              if (pin_low) begin
                if (!pulse_active) begin
                  pulse_active_next   = 1'b1;
                  pulse_start_ms_next = time_ms;
                end
              end else if (pulse_active) begin
                pulse_active_next = 1'b0;
                if (dur >= {16'd0, min_low_ms} && dur <= {16'd0, max_low_ms} &&
                    gap >= {16'd0, min_gap_ms}) begin
                  last_accept_ms_next = time_ms;
                  if (pending_count != rtwc_pkg::PENDING_MAX) begin
                    pending_count_next = pending_count + 16'd1;
                  end
                end
              end
            end
          end else if (now_sec >= epoch_threshold) begin
            valid_r_next       = 1'b1;
            store_left_next    = pending_count;
            pending_count_next = '0;
            tip_total_next     = tip_total + {16'd0, pending_count};
            hour_count_next    = ({1'b0, hour_count} + {{(17-FW){1'b0}}, 1'b0}
                                  + 17'(pending_count) > 17'(rtwc_pkg::RING_DEPTH))
                                 ? FW'(rtwc_pkg::RING_DEPTH)
                                 : FW'({1'b0, hour_count} + 17'(pending_count));
            state_next         = rtwc_pkg::ST_STORE;
          end
        end
      end
      rtwc_pkg::ST_STORE: begin
        // one stamp per cycle, oldest overwritten when full
        if (store_left == 16'd0) begin
          state_next = rtwc_pkg::ST_DAY_RD;
        end else begin
          ram_we          = 1'b1;
          store_left_next = store_left - 16'd1;
          if (ring_fill < FW'(rtwc_pkg::RING_DEPTH)) begin
            ring_fill_next = ring_fill + FW'(1);
          end else begin
            ring_head_next = ring_head + AW'(1);
          end
        end
      end
      rtwc_pkg::ST_DAY_RD: begin
        ram_raddr = ring_head;
        if (ring_fill == '0) begin
          state_next = rtwc_pkg::ST_HOUR_RD;
        end else begin
          state_next = rtwc_pkg::ST_DAY_WAIT;
        end
      end
      rtwc_pkg::ST_DAY_WAIT: begin
        state_next = rtwc_pkg::ST_DAY_CHK;
      end
      rtwc_pkg::ST_DAY_CHK: begin
        if (age < day_window_sec) begin
          state_next = rtwc_pkg::ST_HOUR_RD;
        end else begin
          ring_head_next = ring_head + AW'(1);
          ring_fill_next = ring_fill - FW'(1);
          state_next     = rtwc_pkg::ST_DAY_RD;
        end
      end
      rtwc_pkg::ST_HOUR_RD: begin
        if (hour_count > ring_fill) begin
          hour_count_next = ring_fill;
          state_next      = rtwc_pkg::ST_HOUR_RD;
        end else if (hour_count == '0) begin
          state_next = rtwc_pkg::ST_MUL_HOUR;
        end else begin
          ram_raddr  = ring_head + AW'(ring_fill - hour_count);
          state_next = rtwc_pkg::ST_HOUR_WAIT;
        end
      end
      rtwc_pkg::ST_HOUR_WAIT: begin
        // hold the address so the read data stays on the oldest hour entry
        ram_raddr  = ring_head + AW'(ring_fill - hour_count);
        state_next = rtwc_pkg::ST_HOUR_CHK;
      end
      rtwc_pkg::ST_HOUR_CHK: begin
        if (age < hour_window_sec) begin
          state_next = rtwc_pkg::ST_MUL_HOUR;
        end else begin
          hour_count_next = hour_count - FW'(1);
          state_next      = rtwc_pkg::ST_HOUR_RD;
        end
      end
      rtwc_pkg::ST_MUL_HOUR: begin
        mul_a          = hour_count;
        hour_rain_next = mul_p[25:0];
        state_next     = rtwc_pkg::ST_MUL_DAY;
      end
      rtwc_pkg::ST_MUL_DAY: begin
        mul_a         = ring_fill;
        day_rain_next = mul_p[25:0];
        state_next    = rtwc_pkg::ST_DONE;
      end
      rtwc_pkg::ST_DONE: begin
        state_next = rtwc_pkg::ST_IDLE;
      end
      default: state_next = rtwc_pkg::ST_IDLE;
    endcase
  end

  assign busy         = (state != rtwc_pkg::ST_IDLE);
  assign done         = (state == rtwc_pkg::ST_DONE);
  assign time_valid   = valid_r;
  assign total_tips   = tip_total;
  assign hour_tips    = 11'(hour_count);
  assign day_tips     = 11'(ring_fill);
  assign hour_rain    = hour_rain_r;
  assign day_rain     = day_rain_r;
  assign pending_tips = pending_count;

endmodule

/* hw/rtl/rtwc_checker.sv */
// ----------------------------------------------------------------------------
// rtwc_checker
// port-level checks for the rain tip window counter
// ----------------------------------------------------------------------------
module rtwc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        time_valid,
  input logic [10:0] hour_tips,
  input logic [10:0] day_tips,
  input logic [15:0] pending_tips
);

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("item taken but block not busy");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after result");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result while idle");

  a_hour_le_day: assert property (@(posedge clk) disable iff (rst)
    done |-> hour_tips <= day_tips) else $error("hour count above day count");

  a_tick_clears: assert property (@(posedge clk) disable iff (rst)
    done && time_valid |-> pending_tips == 16'd0) else $error("pending left after tick");

endmodule

bind rain_tip_window_counter rtwc_checker u_rtwc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .time_valid   (time_valid),
  .hour_tips    (hour_tips),
  .day_tips     (day_tips),
  .pending_tips (pending_tips)
);
